// File: design/alr_pkg.sv
// Shared types and constants for the anti-aliased line rasterizer.
`default_nettype none
package alr_pkg;
  localparam int CFG_W = 13;
  localparam int REG_IDX_W = 3;
  localparam int PIX_W = 14;

  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CLIP_LEFT = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_CLIP_TOP = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CLIP_RIGHT = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_CLIP_BOTTOM = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_AXIS,
    ST_WU
  } state_t;

  typedef enum logic [2:0] {
    PH_END0_LO = 3'd0,
    PH_END0_HI = 3'd1,
    PH_END1_LO = 3'd2,
    PH_END1_HI = 3'd3,
    PH_MID_LO = 3'd4,
    PH_MID_HI = 3'd5
  } phase_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch endpoints of a start beat
    logic div_step;  // one quotient bit
    logic emit;      // produce a plot into the output register
    logic advance;   // move along the line after a plot
    logic next_phase;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_axis;
    logic div_done;
    logic last;
  } stat_t;
endpackage
`default_nettype wire

// File: design/alr_ctrl.sv
// Controller state machine: sequences start, slope division and plot beats.
`default_nettype none
module alr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_fire,
  input  wire logic          in_kind,
  input  wire logic          out_free,
  input  wire alr_pkg::stat_t stat,
  output alr_pkg::cmd_t      cmd,
  output logic               in_ready
);
  import alr_pkg::*;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE, ST_AXIS, ST_WU: begin
        if (in_fire && !in_kind) state_next = ST_DIV;
        else if (in_fire && state != ST_IDLE && stat.last) state_next = ST_IDLE;
      end
      ST_DIV: begin
        if (stat.is_axis) state_next = ST_AXIS;
        else if (stat.div_done) state_next = ST_WU;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = out_free;
        cmd.load = in_fire && !in_kind;
      end
      ST_AXIS, ST_WU: begin
        in_ready = out_free;
        cmd.load = in_fire && !in_kind;
        cmd.emit = in_fire && in_kind;
        cmd.advance = in_fire && in_kind && !stat.last;
        cmd.next_phase = in_fire && in_kind;
      end
      ST_DIV: cmd.div_step = 1'b1;
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// File: design/alr_dpath.sv
// Datapath: endpoint setup, restoring slope divider, stepping and plot output.
`default_nettype none
module alr_dpath #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS = 16
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire alr_pkg::cmd_t            cmd,
  output alr_pkg::stat_t                stat,
  input  wire logic [11:0]              start_x,
  input  wire logic [11:0]              start_y,
  input  wire logic [11:0]              end_x,
  input  wire logic [11:0]              end_y,
  input  wire logic [7:0]               alpha,
  input  wire logic [alr_pkg::CFG_W-1:0] origin_x,
  input  wire logic [alr_pkg::CFG_W-1:0] origin_y,
  input  wire logic [alr_pkg::CFG_W-1:0] clip_left,
  input  wire logic [alr_pkg::CFG_W-1:0] clip_top,
  input  wire logic [alr_pkg::CFG_W-1:0] clip_right,
  input  wire logic [alr_pkg::CFG_W-1:0] clip_bottom,
  output logic [alr_pkg::PIX_W-1:0]     pixel_x,
  output logic [alr_pkg::PIX_W-1:0]     pixel_y,
  output logic [7:0]                    plot_alpha,
  output logic                          visible,
  output logic                          last
);
  import alr_pkg::*;
  localparam int CB = COORD_BITS;
  localparam int FB = FRAC_BITS;
  localparam int NB = CB + FB;      // dividend width
  localparam int QW = FB + 2;       // signed slope, +-1.0 fits
  localparam int CNT_W = $clog2(NB + 1);

  logic [CB-1:0] sx, sy, ex, ey;
  assign sx = start_x[CB-1:0];
  assign sy = start_y[CB-1:0];
  assign ex = end_x[CB-1:0];
  assign ey = end_y[CB-1:0];

  logic axis_mode, steep;
  logic [CB-1:0] major_pos, major_end, minor_end;
  logic [NB-1:0] minor_fixed;
  logic [QW-1:0] slope;
  logic [7:0] line_alpha;
  phase_t phase;

  logic [NB-1:0] div_num;
  logic [CB:0] div_rem;
  logic [CB-1:0] div_den;
  logic [QW-1:0] div_quo;
  logic div_neg;
  logic [CNT_W-1:0] div_cnt;

  // start setup
  logic [CB-1:0] ax0, ay0, ax1, ay1, adx, ady, mj0, mn0, mj1, mn1;
  logic st_steep, st_vert;
  always_comb begin
    adx = (sx > ex) ? sx - ex : ex - sx;
    ady = (sy > ey) ? sy - ey : ey - sy;
    st_steep = ady > adx;
    st_vert = (sx == ex);
    ax0 = st_steep ? sy : sx; ay0 = st_steep ? sx : sy;
    ax1 = st_steep ? ey : ex; ay1 = st_steep ? ex : ey;
    if (ax0 > ax1) begin
      mj0 = ax1; mn0 = ay1; mj1 = ax0; mn1 = ay0;
    end else begin
      mj0 = ax0; mn0 = ay0; mj1 = ax1; mn1 = ay1;
    end
  end

  logic [CB:0] rem_sh;
  always_comb rem_sh = {div_rem[CB-1:0], div_num[NB-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_mode <= 1'b0; steep <= 1'b0; major_pos <= '0; major_end <= '0;
      minor_fixed <= '0; slope <= '0; phase <= PH_END0_LO; line_alpha <= '0;
      minor_end <= '0; div_cnt <= '0;
    end else begin
      if (cmd.load) begin
        line_alpha <= alpha;
        phase <= PH_END0_LO;
        div_cnt <= '0;
        div_rem <= '0;
        div_quo <= '0;
        if (sx == ex || sy == ey) begin
          axis_mode <= 1'b1;
          steep <= st_vert;
          minor_fixed <= {(st_vert ? sx : sy), {FB{1'b0}}};
          major_pos <= st_vert ? ((sy < ey) ? sy : ey) : ((sx < ex) ? sx : ex);
          major_end <= st_vert ? ((sy < ey) ? ey : sy) : ((sx < ex) ? ex : sx);
          slope <= '0;
        end else begin
          axis_mode <= 1'b0;
          steep <= st_steep;
          major_pos <= mj0; major_end <= mj1;
          minor_fixed <= {mn0, {FB{1'b0}}};
          minor_end <= mn1;
          div_neg <= mn1 < mn0;
          div_num <= {((mn1 < mn0) ? mn0 - mn1 : mn1 - mn0), {FB{1'b0}}};
          div_den <= mj1 - mj0;
        end
      end else if (cmd.div_step) begin
        div_cnt <= div_cnt + 1'b1;
        div_num <= {div_num[NB-2:0], 1'b0};
        if (rem_sh >= {1'b0, div_den}) begin
          div_rem <= rem_sh - {1'b0, div_den};
          div_quo <= {div_quo[QW-2:0], 1'b1};
        end else begin
          div_rem <= rem_sh;
          div_quo <= {div_quo[QW-2:0], 1'b0};
        end
        if (div_cnt == CNT_W'(NB - 1))
          slope <= div_neg ? QW'(0) - {div_quo[QW-2:0], (rem_sh >= {1'b0, div_den})}
                           : {div_quo[QW-2:0], (rem_sh >= {1'b0, div_den})};
      end else begin
        if (cmd.next_phase && !axis_mode) begin
          case (phase)
            PH_END0_LO: phase <= PH_END0_HI;
            PH_END0_HI: phase <= PH_END1_LO;
            PH_END1_LO: phase <= PH_END1_HI;
            PH_END1_HI: phase <= PH_MID_LO;
            PH_MID_LO: phase <= PH_MID_HI;
            default: phase <= PH_MID_LO;
          endcase
        end
        if (cmd.advance && (axis_mode || phase == PH_END1_HI || phase == PH_MID_HI)) begin
          major_pos <= major_pos + 1'b1;
          if (!axis_mode) minor_fixed <= minor_fixed + {{(NB-QW){slope[QW-1]}}, slope};
        end
      end
    end
  end

  logic near_end;
  assign near_end = ({1'b0, major_pos} + 1'b1) >= {1'b0, major_end};
  always_comb begin
    stat.is_axis = axis_mode;
    stat.div_done = (div_cnt == CNT_W'(NB));
    if (axis_mode) stat.last = major_pos >= major_end;
    else if (phase == PH_END1_HI || phase == PH_MID_HI) stat.last = near_end;
    else stat.last = 1'b0;
  end

  // plot generation
  logic [CB-1:0] mj, mn_int;
  logic [CB:0] mn;
  logic [8:0] wt;
  logic [7:0] f8;
  always_comb begin
    mn_int = minor_fixed[NB-1:FB];
    f8 = minor_fixed[FB-1:FB-8];
    mj = major_pos;
    mn = {1'b0, mn_int};
    wt = 9'd128;
    case (phase)
      PH_END0_LO: wt = 9'd128;
      PH_END0_HI: begin mn = {1'b0, mn_int} + 1'b1; wt = 9'd0; end
      PH_END1_LO: begin mj = major_end; mn = {1'b0, minor_end}; wt = 9'd128; end
      PH_END1_HI: begin mj = major_end; mn = {1'b0, minor_end} + 1'b1; wt = 9'd0; end
      PH_MID_LO: wt = 9'd256 - {1'b0, f8};
      default: begin mn = {1'b0, mn_int} + 1'b1; wt = {1'b0, f8}; end
    endcase
  end

  logic [CB:0] px, py;
  logic [PIX_W-1:0] tx, ty;
  logic [16:0] prod;
  always_comb begin
    px = steep ? mn : {1'b0, mj};
    py = steep ? {1'b0, mj} : mn;
    tx = PIX_W'(px) + {origin_x[CFG_W-1], origin_x};
    ty = PIX_W'(py) + {origin_y[CFG_W-1], origin_y};
    prod = line_alpha * wt;
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      pixel_x <= tx;
      pixel_y <= ty;
      plot_alpha <= axis_mode ? line_alpha : prod[15:8];
      visible <= !tx[PIX_W-1] && !ty[PIX_W-1]
        && (tx[CFG_W-1:0] >= clip_left) && (tx[CFG_W-1:0] < clip_right)
        && (ty[CFG_W-1:0] >= clip_top) && (ty[CFG_W-1:0] < clip_bottom);
      last <= stat.last;
    end
  end
endmodule
`default_nettype wire

// File: design/antialiased_line_rasterizer_unit.sv
// Top level of the anti-aliased line rasterizer.
// Input beats on s_axis: tuser = kind (0 start, 1 step), tdata holds the
// endpoints and alpha. A start beat produces no output. For a sloped line it
// is followed by a slope division (one quotient bit per cycle in a restoring
// divider); an axis line instead takes a setup step in the divide state.
// s_axis_tready is low during either. Each step beat produces one plot beat,
// registered and shown on m_axis in the cycle after it is taken; tlast
// marks the final plot of the line. Step beats flow one per cycle while the
// output register is empty or being drained; a stalled receiver holds the
// plot and s_axis_tready drops until it is taken. A step with no line running
// produces nothing. Clipped plots come out with visible = 0.
// Reset: clip rectangle 0..4096, origin 0, block idle. Configuration writes
// must be made only while idle; the block itself does not enforce this.
`default_nettype none
module antialiased_line_rasterizer_unit #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [55:0] s_axis_tdata,   // start_x, start_y, end_x, end_y, alpha
  input  wire logic        s_axis_tuser,   // kind
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [39:0]      m_axis_tdata,   // pixel_x, pixel_y, plot_alpha, pad
  output logic             m_axis_tuser,   // visible
  output logic             m_axis_tlast,   // last
  input  wire logic        cfg_we,
  input  wire logic [alr_pkg::REG_IDX_W-1:0] cfg_index,
  input  wire logic [alr_pkg::CFG_W-1:0]     cfg_data
);
  import alr_pkg::*;
  logic [CFG_W-1:0] origin_x, origin_y, clip_left, clip_top, clip_right, clip_bottom;
  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x <= '0; origin_y <= '0; clip_left <= '0; clip_top <= '0;
      clip_right <= 13'd4096; clip_bottom <= 13'd4096;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_ORIGIN_X: origin_x <= cfg_data;
        REG_ORIGIN_Y: origin_y <= cfg_data;
        REG_CLIP_LEFT: clip_left <= cfg_data;
        REG_CLIP_TOP: clip_top <= cfg_data;
        REG_CLIP_RIGHT: clip_right <= cfg_data;
        REG_CLIP_BOTTOM: clip_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  cmd_t cmd;
  stat_t stat;
  logic in_fire, out_free, ovalid;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign out_free = !ovalid || m_axis_tready;

  alr_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_fire(in_fire), .in_kind(s_axis_tuser),
    .out_free(out_free), .stat(stat), .cmd(cmd), .in_ready(s_axis_tready)
  );

  logic [PIX_W-1:0] pixel_x, pixel_y;
  logic [7:0] plot_alpha;
  alr_dpath #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_dpath (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .start_x(s_axis_tdata[11:0]), .start_y(s_axis_tdata[23:12]),
    .end_x(s_axis_tdata[35:24]), .end_y(s_axis_tdata[47:36]),
    .alpha(s_axis_tdata[55:48]),
    .origin_x(origin_x), .origin_y(origin_y), .clip_left(clip_left),
    .clip_top(clip_top), .clip_right(clip_right), .clip_bottom(clip_bottom),
    .pixel_x(pixel_x), .pixel_y(pixel_y), .plot_alpha(plot_alpha),
    .visible(m_axis_tuser), .last(m_axis_tlast)
  );

  always_ff @(posedge clk) begin
    if (rst) ovalid <= 1'b0;
    else if (cmd.emit) ovalid <= 1'b1;
    else if (m_axis_tready) ovalid <= 1'b0;
  end
  assign m_axis_tvalid = ovalid;
  assign m_axis_tdata = {4'b0000, plot_alpha, pixel_y, pixel_x};
endmodule
`default_nettype wire

// File: design/alr_checker.sv
// Port-level checker for the rasterizer, bound to the top level.
`default_nettype none
module alr_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic s_axis_tvalid,
  input wire logic s_axis_tready,
  input wire logic s_axis_tuser,
  input wire logic m_axis_tvalid,
  input wire logic m_axis_tready,
  input wire logic [39:0] m_axis_tdata
);
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output beat changed under stall");
  a_no_accept_when_full: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while output full");
  a_start_silent: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser && !(m_axis_tvalid && !m_axis_tready)
    |=> !m_axis_tvalid)
    else $error("start beat produced a plot");
  a_div_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> !s_axis_tready)
    else $error("ready during slope setup");
endmodule

bind antialiased_line_rasterizer_unit alr_checker u_alr_checker (
  .clk(clk), .rst(rst), .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
  .s_axis_tuser(s_axis_tuser), .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready), .m_axis_tdata(m_axis_tdata)
);
`default_nettype wire
